// ===== src/bit_vector_rank_access_assert.svh =====
// assertion macros for the bit vector rank/access block
// used by the port checker, no other dependencies
`ifndef BIT_VECTOR_RANK_ACCESS_ASSERT_SVH
`define BIT_VECTOR_RANK_ACCESS_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define BVRA_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: check failed");

// next-cycle implication, disabled while reset is active
`define BVRA_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

// ===== src/bvra_pkg.sv =====
// shared constants, codes, types and the popcount function of the rank/access block
// no dependencies
package bvra_pkg;

  // sizes, all powers of two
  localparam int unsigned WORD_BITS       = 64;
  localparam int unsigned SUPERBLOCK_BITS = 512;
  localparam int unsigned MAX_BITS        = 65536;

  localparam int unsigned NUM_WORDS       = MAX_BITS / WORD_BITS;
  localparam int unsigned NUM_SB          = MAX_BITS / SUPERBLOCK_BITS;
  localparam int unsigned WORDS_PER_SB    = SUPERBLOCK_BITS / WORD_BITS;

  localparam int unsigned WOFF_W          = $clog2(WORD_BITS);
  localparam int unsigned SB_LOG2         = $clog2(SUPERBLOCK_BITS);
  localparam int unsigned WPS_LOG2        = $clog2(WORDS_PER_SB);
  localparam int unsigned WORD_IDX_W      = $clog2(NUM_WORDS);
  localparam int unsigned SB_IDX_W        = $clog2(NUM_SB);
  localparam int unsigned LEN_W           = $clog2(MAX_BITS) + 1;

  // fixed field widths
  localparam int unsigned POS_W           = 16;
  localparam int unsigned CNT_W           = 17;
  localparam int unsigned IN_TDATA_W      = 24;
  localparam int unsigned OUT_TDATA_W     = 40;

  // action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORD,
    ST_DONE
  } state_e;

  // one word to count, first bit in the msb
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [WOFF_W-1:0]    off;
    logic                 last;
  } cnt_req_t;

  typedef struct packed {
    logic [WOFF_W:0] ones;
    logic            bit_value;
  } cnt_rsp_t;

  function automatic logic [WOFF_W:0] popcount(logic [WORD_BITS-1:0] w);
    logic [WOFF_W:0] c;
    c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c + (WOFF_W+1)'(w[i]);
    end
    return c;
  endfunction

endpackage

// ===== src/bvra_word_count.sv =====
// ones count of one word, cut after the queried bit when it is the position's word
// depends on bvra_pkg
module bvra_word_count (
  input  bvra_pkg::cnt_req_t req_i,
  output bvra_pkg::cnt_rsp_t rsp_o
);

  logic [bvra_pkg::WORD_BITS-1:0] ones_mask;
  logic [bvra_pkg::WOFF_W:0]      keep_n;
  logic [bvra_pkg::WOFF_W-1:0]    bit_idx;

  // keep bits from the msb down to and including the offset
  assign keep_n    = {1'b0, req_i.off} + (bvra_pkg::WOFF_W+1)'(1);
  assign ones_mask = req_i.last ? ~({bvra_pkg::WORD_BITS{1'b1}} >> keep_n)
                                : {bvra_pkg::WORD_BITS{1'b1}};
  assign bit_idx   = bvra_pkg::WOFF_W'(bvra_pkg::WORD_BITS - 1) - req_i.off;

  assign rsp_o.ones      = bvra_pkg::popcount(req_i.word & ones_mask);
  assign rsp_o.bit_value = req_i.word[bit_idx];

endmodule

// ===== src/bit_vector_rank_access.sv =====
// Rank/access bit vector. Items on the input stream clear the vector, append one bit or
// query a position; every item gives exactly one result. Bits are packed msb first into
// 64-bit words held in a 1024-entry word memory, and the ones count at the end of each
// 512-bit superblock sits in a 128-entry count memory. Clear, append, an unused action
// and an out-of-range query are answered directly from the idle state. A query in range
// goes through the request, a counting step for each word from the superblock start up to
// the position's word (the word memory gives one word per cycle), and a step to form the
// result. A new request is taken only when no result waits on the output or the waiting
// one leaves in the same cycle.
// No clearing pass after reset: only written entries are ever read.
// depends on bvra_pkg and bvra_word_count
module bit_vector_rank_access (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // bit_in [0], position [16:1], zero [23:17]
  input  logic [bvra_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action [1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // ones_count [16:0], zeros_count [33:17], bit_value [34], zero [39:35]
  output logic [bvra_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status [1:0]
  output logic [1:0]                          m_axis_tuser
);

  localparam int unsigned W  = bvra_pkg::WORD_BITS;
  localparam int unsigned CW = bvra_pkg::CNT_W;

  // memories
  logic [W-1:0]  word_mem [bvra_pkg::NUM_WORDS];
  logic [CW-1:0] sb_mem   [bvra_pkg::NUM_SB];
  logic [W-1:0]  word_rd_q;
  logic [CW-1:0] sb_rd_q;

  logic                           word_we, word_re, sb_we, sb_re;
  logic [bvra_pkg::WORD_IDX_W-1:0] word_waddr, word_raddr;
  logic [bvra_pkg::SB_IDX_W-1:0]   sb_waddr, sb_raddr;

  // control and payload state
  bvra_pkg::state_e                state_q, state_d;
  logic [bvra_pkg::LEN_W-1:0]      bit_len_q, bit_len_d;
  logic [CW-1:0]                   run_ones_q, run_ones_d;
  logic [W-1:0]                    partial_q, partial_d;
  logic [bvra_pkg::POS_W-1:0]      pos_q, pos_d;
  logic [bvra_pkg::WORD_IDX_W-1:0] cur_q, cur_d, last_q, last_d;
  logic                            first_q, first_d, sb_zero_q, sb_zero_d;
  logic [CW-1:0]                   rank_q, rank_d;
  logic                            bit_q, bit_d;

  logic                            out_valid_q, out_valid_d;
  logic [CW-1:0]                   out_ones_q, out_ones_d, out_zeros_q, out_zeros_d;
  logic                            out_bit_q, out_bit_d;
  logic [1:0]                      out_stat_q, out_stat_d;

  // request fields
  logic                            in_fire, out_free;
  logic [1:0]                      act;
  logic                            bit_in;
  logic [bvra_pkg::POS_W-1:0]      pos_in;

  logic                            app_ok, word_done, sb_done, in_range;
  logic [bvra_pkg::LEN_W-1:0]      bl_inc;
  logic [W-1:0]                    partial_shift, partial_aligned;
  logic [CW-1:0]                   ones_inc;
  logic [31:0]                     pos_sb;
  logic [bvra_pkg::WORD_IDX_W-1:0] pos_word, pos_first;
  logic [bvra_pkg::WOFF_W-1:0]     fill;

  bvra_pkg::cnt_req_t              cnt_req;
  bvra_pkg::cnt_rsp_t              cnt_rsp;

  assign act      = s_axis_tuser;
  assign bit_in   = s_axis_tdata[0];
  assign pos_in   = s_axis_tdata[bvra_pkg::POS_W:1];
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == bvra_pkg::ST_IDLE) && out_free;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  assign app_ok        = bit_len_q != bvra_pkg::LEN_W'(bvra_pkg::MAX_BITS);
  assign bl_inc        = bit_len_q + bvra_pkg::LEN_W'(1);
  assign partial_shift = {partial_q[W-2:0], bit_in};
  assign ones_inc      = run_ones_q + CW'(bit_in);
  assign word_done     = bl_inc[bvra_pkg::WOFF_W-1:0] == '0;
  assign sb_done       = bl_inc[bvra_pkg::SB_LOG2-1:0] == '0;
  assign word_waddr    = bit_len_q[bvra_pkg::WOFF_W +: bvra_pkg::WORD_IDX_W];
  assign sb_waddr      = bit_len_q[bvra_pkg::SB_LOG2 +: bvra_pkg::SB_IDX_W];

  assign in_range  = 32'(pos_in) < 32'(bit_len_q);
  assign pos_sb    = 32'(pos_in) >> bvra_pkg::SB_LOG2;
  assign pos_word  = bvra_pkg::WORD_IDX_W'(32'(pos_in) >> bvra_pkg::WOFF_W);
  assign pos_first = bvra_pkg::WORD_IDX_W'(pos_sb << bvra_pkg::WPS_LOG2);

  // the word being filled, moved up to the msb
  assign fill            = bit_len_q[bvra_pkg::WOFF_W-1:0];
  assign partial_aligned = partial_q << ((bvra_pkg::WOFF_W+1)'(W) - {1'b0, fill});

  assign cnt_req.word = (32'(cur_q) < (32'(bit_len_q) >> bvra_pkg::WOFF_W)) ? word_rd_q
                                                                           : partial_aligned;
  assign cnt_req.off  = pos_q[bvra_pkg::WOFF_W-1:0];
  assign cnt_req.last = cur_q == last_q;

  bvra_word_count u_word_count (
    .req_i (cnt_req),
    .rsp_o (cnt_rsp)
  );

  always_comb begin
    state_d     = state_q;
    bit_len_d   = bit_len_q;
    run_ones_d  = run_ones_q;
    partial_d   = partial_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    last_d      = last_q;
    first_d     = first_q;
    sb_zero_d   = sb_zero_q;
    rank_d      = rank_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ones_d  = out_ones_q;
    out_zeros_d = out_zeros_q;
    out_bit_d   = out_bit_q;
    out_stat_d  = out_stat_q;
    word_we     = 1'b0;
    sb_we       = 1'b0;
    word_re     = 1'b0;
    sb_re       = 1'b0;
    word_raddr  = cur_q;
    sb_raddr    = bvra_pkg::SB_IDX_W'(pos_sb - 32'd1);

    case (state_q)
      bvra_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_d = 1'b1;
          out_ones_d  = '0;
          out_zeros_d = '0;
          out_bit_d   = 1'b0;
          out_stat_d  = bvra_pkg::STAT_OK;
          case (act)
            bvra_pkg::ACT_CLEAR: begin
              bit_len_d  = '0;
              run_ones_d = '0;
              partial_d  = '0;
            end
            bvra_pkg::ACT_APPEND: begin
              if (app_ok) begin
                bit_len_d  = bl_inc;
                run_ones_d = ones_inc;
                partial_d  = word_done ? '0 : partial_shift;
                word_we    = word_done;
                sb_we      = sb_done;
              end else begin
                out_stat_d = bvra_pkg::STAT_FULL;
              end
            end
            bvra_pkg::ACT_QUERY: begin
              if (in_range) begin
                out_valid_d = 1'b0;
                pos_d       = pos_in;
                cur_d       = pos_first;
                last_d      = pos_word;
                first_d     = 1'b1;
                sb_zero_d   = pos_sb == 32'd0;
                rank_d      = '0;
                word_re     = 1'b1;
                word_raddr  = pos_first;
                sb_re       = pos_sb != 32'd0;
                state_d     = bvra_pkg::ST_WORD;
              end else begin
                out_stat_d = bvra_pkg::STAT_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bvra_pkg::ST_WORD: begin
        // superblock count joins the sum with the first word
        rank_d  = rank_q + CW'(cnt_rsp.ones)
                + ((first_q && !sb_zero_q) ? sb_rd_q : '0);
        first_d = 1'b0;
        if (cnt_req.last) begin
          bit_d   = cnt_rsp.bit_value;
          state_d = bvra_pkg::ST_DONE;
        end else begin
          cur_d      = cur_q + bvra_pkg::WORD_IDX_W'(1);
          word_re    = 1'b1;
          word_raddr = cur_q + bvra_pkg::WORD_IDX_W'(1);
        end
      end
      bvra_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ones_d  = rank_q;
          out_zeros_d = CW'(pos_q) + CW'(1) - rank_q;
          out_bit_d   = bit_q;
          out_stat_d  = bvra_pkg::STAT_OK;
          state_d     = bvra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bvra_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bvra_pkg::ST_IDLE;
      bit_len_q   <= '0;
      run_ones_q  <= '0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_len_q   <= bit_len_d;
      run_ones_q  <= run_ones_d;
      partial_q   <= partial_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cur_q       <= cur_d;
    last_q      <= last_d;
    first_q     <= first_d;
    sb_zero_q   <= sb_zero_d;
    rank_q      <= rank_d;
    bit_q       <= bit_d;
    out_ones_q  <= out_ones_d;
    out_zeros_q <= out_zeros_d;
    out_bit_q   <= out_bit_d;
    out_stat_q  <= out_stat_d;
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[word_waddr] <= partial_shift;
    end
    if (word_re) begin
      word_rd_q <= word_mem[word_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sb_we) begin
      sb_mem[sb_waddr] <= ones_inc;
    end
    if (sb_re) begin
      sb_rd_q <= sb_mem[sb_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(bvra_pkg::OUT_TDATA_W - 2 * CW - 1)'(0),
                          out_bit_q, out_zeros_q, out_ones_q};
  assign m_axis_tuser  = out_stat_q;

endmodule

// ===== src/bvra_checker.sv =====
// port-level checks on the result stream of the rank/access block, bound to the top level
// depends on bvra_pkg and bit_vector_rank_access_assert.svh
`include "bit_vector_rank_access_assert.svh"

module bvra_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bvra_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                       m_axis_tuser
);

  // a stalled result keeps its payload
  `BVRA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // error results carry no counts and no bit
  `BVRA_ASSERT_IMP(a_range_zero, clk_i, rst_ni,
                   m_axis_tvalid && (m_axis_tuser == bvra_pkg::STAT_RANGE),
                   m_axis_tdata == '0)

  `BVRA_ASSERT_IMP(a_full_zero, clk_i, rst_ni,
                   m_axis_tvalid && (m_axis_tuser == bvra_pkg::STAT_FULL),
                   m_axis_tdata == '0)

  // a set bit at the position counts itself
  `BVRA_ASSERT_IMP(a_bit_counted, clk_i, rst_ni,
                   m_axis_tvalid && m_axis_tdata[2 * bvra_pkg::CNT_W],
                   m_axis_tdata[bvra_pkg::CNT_W-1:0] != '0)

endmodule

bind bit_vector_rank_access bvra_checker u_bvra_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for bit_vector_rank_access: directed and random clear/append/query/unused-action requests against a
// bit-exact predictor of the rank/access vector, with random stalls on both streams
// depends on bvra_pkg and the bit_vector_rank_access rtl
module tb_top;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned HOLD_AT      = 1500;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 32;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    PACE_OPEN,
    PACE_RANDOM,
    PACE_STALL
  } pace_e;

  typedef struct {
    logic [1:0]                 action;
    logic                       bit_in;
    logic [bvra_pkg::POS_W-1:0] position;
    bit                         drain_before;
  } vec_req_t;

  typedef struct packed {
    logic [bvra_pkg::CNT_W-1:0] ones;
    logic [bvra_pkg::CNT_W-1:0] zeros;
    logic                       bit_value;
    logic [1:0]                 status;
  } vec_rsp_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [bvra_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]                       s_axis_tuser  = bvra_pkg::ACT_CLEAR;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [bvra_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                       m_axis_tuser;

  vec_req_t    pending_reqs[$];
  vec_rsp_t    awaited_results[$];
  vec_req_t    cur_req;
  int unsigned mismatch_cnt = 0;

  // sender burst/gap bookkeeping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // receiver pacing
  pace_e       pace_mode = PACE_OPEN;
  int unsigned pace_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;

  // stimulus generator view of the vector length
  int unsigned gen_len   = 0;
  int unsigned gen_items = 0;

  // predictor state
  logic [bvra_pkg::WORD_BITS-1:0] bv_words [bvra_pkg::NUM_WORDS];
  logic [bvra_pkg::CNT_W-1:0]     sb_ones  [bvra_pkg::NUM_SB];
  logic [bvra_pkg::LEN_W-1:0]     bv_len     = '0;
  logic [bvra_pkg::CNT_W-1:0]     bv_ones    = '0;
  logic [bvra_pkg::WORD_BITS-1:0] bv_partial = '0;

  bit_vector_rank_access DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    #(2 * CLK_PERIOD) rst_ni = 1'b1;
  end

  // word j left aligned; the word being filled comes from the partial register
  function automatic logic [bvra_pkg::WORD_BITS-1:0] word_at(int unsigned j);
    int unsigned full;
    int unsigned fill;
    full = bv_len / bvra_pkg::WORD_BITS;
    fill = bv_len % bvra_pkg::WORD_BITS;
    if (j < full) return bv_words[j];
    if (j == full && fill != 0) return bv_partial << (bvra_pkg::WORD_BITS - fill);
    return '0;
  endfunction

  function automatic vec_rsp_t bv_apply(vec_req_t req);
    vec_rsp_t                       rsp;
    int unsigned                    pos;
    int unsigned                    sb;
    int unsigned                    last;
    int unsigned                    off;
    int unsigned                    rank;
    logic [bvra_pkg::WORD_BITS-1:0] w;
    rsp = '0;
    case (req.action)
      bvra_pkg::ACT_CLEAR: begin
        bv_len     = '0;
        bv_ones    = '0;
        bv_partial = '0;
      end
      bvra_pkg::ACT_APPEND: begin
        if (bv_len == bvra_pkg::LEN_W'(bvra_pkg::MAX_BITS)) begin
          rsp.status = bvra_pkg::STAT_FULL;
        end else begin
          bv_partial = {bv_partial[bvra_pkg::WORD_BITS-2:0], req.bit_in};
          bv_ones    = bv_ones + bvra_pkg::CNT_W'(req.bit_in);
          bv_len     = bv_len + 1'b1;
          if (bv_len % bvra_pkg::WORD_BITS == 0) begin
            bv_words[bv_len / bvra_pkg::WORD_BITS - 1] = bv_partial;
            bv_partial = '0;
          end
          if (bv_len % bvra_pkg::SUPERBLOCK_BITS == 0) begin
            sb_ones[bv_len / bvra_pkg::SUPERBLOCK_BITS - 1] = bv_ones;
          end
        end
      end
      bvra_pkg::ACT_QUERY: begin
        pos = req.position;
        if (pos >= bv_len) begin
          rsp.status = bvra_pkg::STAT_RANGE;
        end else begin
          sb   = pos / bvra_pkg::SUPERBLOCK_BITS;
          last = pos / bvra_pkg::WORD_BITS;
          off  = pos % bvra_pkg::WORD_BITS;
          rank = (sb > 0) ? sb_ones[sb - 1] : 0;
          for (int unsigned j = sb * bvra_pkg::WORDS_PER_SB; j < last; j++) begin
            rank += $countones(word_at(j));
          end
          // leading bits of the position's word, the queried bit ends up in bit 0
          w = word_at(last) >> (bvra_pkg::WORD_BITS - 1 - off);
          rank += $countones(w);
          rsp.ones      = bvra_pkg::CNT_W'(rank);
          rsp.zeros     = bvra_pkg::CNT_W'(pos + 1 - rank);
          rsp.bit_value = w[0];
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  task automatic add_req(logic [1:0] action, logic bit_in,
                         logic [bvra_pkg::POS_W-1:0] position, bit drain);
    vec_req_t req;
    req.action       = action;
    req.bit_in       = bit_in;
    req.position     = position;
    req.drain_before = drain;
    pending_reqs.push_back(req);
    gen_items++;
    if (action == bvra_pkg::ACT_CLEAR) gen_len = 0;
    else if (action == bvra_pkg::ACT_APPEND && gen_len < bvra_pkg::MAX_BITS) gen_len++;
  endtask

  // in-range position, biased toward the ends, word starts and superblock ends
  function automatic logic [bvra_pkg::POS_W-1:0] pick_pos(int unsigned len);
    int unsigned p;
    case ($urandom_range(0, 5))
      0: p = 0;
      1: p = len - 1;
      2: begin
        p = $urandom_range(0, len - 1) | (bvra_pkg::SUPERBLOCK_BITS - 1);
        if (p > len - 1) p = len - 1;
      end
      3: p = $urandom_range(0, len - 1) & ~(bvra_pkg::WORD_BITS - 1);
      default: p = $urandom_range(0, len - 1);
    endcase
    return bvra_pkg::POS_W'(p);
  endfunction

  initial begin
    int unsigned seg_target;
    int unsigned seg_end;
    int unsigned run_len;
    int unsigned dens;
    int unsigned r;
    int unsigned sel;

    // directed part
    add_req(bvra_pkg::ACT_QUERY,  1'b1, '0,        1'b0);
    add_req(bvra_pkg::ACT_APPEND, 1'b1, 16'hFFFF,  1'b0);
    add_req(bvra_pkg::ACT_APPEND, 1'b0, 16'h0000,  1'b0);
    add_req(bvra_pkg::ACT_APPEND, 1'b1, 16'hA5A5,  1'b0);
    add_req(bvra_pkg::ACT_QUERY,  1'b0, 16'd0,     1'b0);
    add_req(bvra_pkg::ACT_QUERY,  1'b1, 16'd1,     1'b0);
    add_req(bvra_pkg::ACT_QUERY,  1'b0, 16'd2,     1'b0);
    add_req(bvra_pkg::ACT_QUERY,  1'b1, 16'd3,     1'b0);
    add_req(bvra_pkg::ACT_QUERY,  1'b0, 16'hFFFF,  1'b0);
    add_req(ACT_UNUSED,           1'b1, 16'hFFFF,  1'b0);
    add_req(ACT_UNUSED,           1'b0, 16'h0000,  1'b0);
    add_req(bvra_pkg::ACT_QUERY,  1'b0, 16'd2,     1'b1);
    add_req(bvra_pkg::ACT_CLEAR,  1'b1, 16'hFFFF,  1'b0);
    add_req(bvra_pkg::ACT_QUERY,  1'b1, 16'd0,     1'b0);
    add_req(bvra_pkg::ACT_APPEND, 1'b0, 16'h5A5A,  1'b1);
    add_req(bvra_pkg::ACT_QUERY,  1'b1, 16'd0,     1'b0);
    add_req(bvra_pkg::ACT_CLEAR,  1'b0, 16'h0000,  1'b0);

    // random segments, each starting from an empty vector
    seg_end = gen_items + RANDOM_ITEMS;
    while (gen_items < seg_end) begin
      add_req(bvra_pkg::ACT_CLEAR, 1'($urandom), bvra_pkg::POS_W'($urandom),
              $urandom_range(0, 4) == 0);
      seg_target = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 700)
                                             : $urandom_range(700, 2600);
      dens = ($urandom_range(0, 3) == 0) ? 100 * $urandom_range(0, 1)
                                         : $urandom_range(0, 100);
      r = gen_items + $urandom_range(20, 400);
      while (gen_items < r && gen_items < seg_end) begin
        sel = $urandom_range(0, 99);
        if (sel <= 5) begin
          if (gen_len < bvra_pkg::MAX_BITS) begin
            add_req(bvra_pkg::ACT_QUERY, 1'($urandom),
                    bvra_pkg::POS_W'($urandom_range(0, 1) ? gen_len
                                                          : $urandom_range(gen_len, 65535)),
                    1'b0);
          end
        end else if (sel <= 9) begin
          add_req(ACT_UNUSED, 1'($urandom), bvra_pkg::POS_W'($urandom), 1'b0);
        end else begin
          if (gen_len == 0 || (gen_len < seg_target && $urandom_range(0, 1) == 1)) begin
            run_len = $urandom_range(1, 48);
            repeat (run_len) begin
              add_req(bvra_pkg::ACT_APPEND, $urandom_range(0, 99) < dens,
                      bvra_pkg::POS_W'($urandom), 1'b0);
            end
          end else begin
            add_req(bvra_pkg::ACT_QUERY, 1'($urandom), pick_pos(gen_len), 1'b0);
          end
        end
      end
    end

    while (pending_reqs.size() != 0 || s_axis_tvalid || awaited_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(64'd80_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // request driver: bursts of requests with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    logic     offer;
    vec_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= bvra_pkg::ACT_CLEAR;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(bv_apply(cur_req));
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].drain_before || awaited_results.size() == 0)) begin
          nxt = pending_reqs.pop_front();
          cur_req = nxt;
          s_axis_tdata <= {{(bvra_pkg::IN_TDATA_W - bvra_pkg::POS_W - 1){1'b0}},
                           nxt.position, nxt.bit_in};
          s_axis_tuser <= nxt.action;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // one long receiver hold-off while requests keep coming
  always @(posedge clk_i or negedge rst_ni) begin : hold_timer
    if (!rst_ni) begin
      cycle_cnt <= 0;
      hold_left <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == HOLD_AT) hold_left <= HOLD_CYCLES;
      else if (hold_left > 0) hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : rsp_pacer
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      pace_mode = PACE_OPEN;
      pace_left = 0;
    end else begin
      if (pace_left == 0) begin
        pace_mode = pace_e'($urandom_range(0, 2));
        pace_left = $urandom_range(1, 30);
      end else begin
        pace_left--;
      end
      m_axis_tready <= (hold_left == 0) &&
                       (pace_mode == PACE_OPEN ||
                        (pace_mode == PACE_RANDOM && $urandom_range(0, 1) == 1));
    end
  end

  always @(posedge clk_i) begin : rsp_monitor
    vec_rsp_t got;
    vec_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ones      = m_axis_tdata[bvra_pkg::CNT_W-1:0];
      got.zeros     = m_axis_tdata[2*bvra_pkg::CNT_W-1:bvra_pkg::CNT_W];
      got.bit_value = m_axis_tdata[2*bvra_pkg::CNT_W];
      got.status    = m_axis_tuser;
      if (awaited_results.size() == 0) begin
        if (mismatch_cnt < 10) begin
          $display("%0t: result with no request pending: ones %0d zeros %0d bit %0d status %0d",
                   $realtime, got.ones, got.zeros, got.bit_value, got.status);
        end
        mismatch_cnt++;
      end else begin
        want = awaited_results.pop_front();
        if (got.ones !== want.ones || got.zeros !== want.zeros ||
            got.bit_value !== want.bit_value || got.status !== want.status) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: mismatch exp ones %0d zeros %0d bit %0d status %0d",
                     $realtime, want.ones, want.zeros, want.bit_value, want.status);
            $display("%0t:          got ones %0d zeros %0d bit %0d status %0d",
                     $realtime, got.ones, got.zeros, got.bit_value, got.status);
          end
          mismatch_cnt++;
        end
      end
    end
  end

endmodule
